@@ rtl/core/ultrasonic_ranger_scan_sequencer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Ranger scan sequencer assertion macros
// Concurrent assertion helpers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGER_SCAN_SEQUENCER_TOP_MACROS_SVH
`define ULTRASONIC_RANGER_SCAN_SEQUENCER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition holds in the same cycle as the trigger.
`define USS_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("sequencer check failed");
// Condition holds in the cycle after the trigger.
`define USS_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("sequencer check failed");
`else
`define USS_ASSERT_SAME(label, clk, rst, trig, cond)
`define USS_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

@@ rtl/core/uss_pkg.sv @@
// ----------------------------------------------------------------------------
// Ranger scan sequencer package
// Types, command and register codes shared by the sequencer modules.
// ----------------------------------------------------------------------------
package uss_pkg;

   // Sensors in one scan; the order and mux tables hold four entries.
   localparam int SENSOR_COUNT = 4;
   localparam int SCAN_LEN = (SENSOR_COUNT > 4) ? 4 : ((SENSOR_COUNT < 1) ? 1 : SENSOR_COUNT);
   localparam logic [1:0] POS_LAST = 2'(SCAN_LEN - 1);

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RISE  = 2'd1,
      CMD_FALL  = 2'd2,
      CMD_START = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PHASE_IDLE    = 3'd0,
      PHASE_POWER   = 3'd1,
      PHASE_TRIGGER = 3'd2,
      PHASE_RISE    = 3'd3,
      PHASE_FALL    = 3'd4
   } phase_type;

   localparam logic [2:0] CSR_TRIGGER_TICKS = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT_TICKS = 3'd1;
   localparam logic [2:0] CSR_CAPTURE_WRAP  = 3'd2;
   localparam logic [2:0] CSR_POWER_TICKS   = 3'd3;
   localparam logic [2:0] CSR_DIST_SCALE    = 3'd4;
   localparam logic [2:0] CSR_ORDER_TABLE   = 3'd5;
   localparam logic [2:0] CSR_MUX_TABLE     = 3'd6;

   typedef struct packed {
      logic [7:0]  trigger_ticks;
      logic [15:0] timeout_ticks;
      logic [15:0] capture_wrap;
      logic [7:0]  power_cycle_ticks;
      logic [15:0] distance_scale;
      logic [7:0]  order_table;
      logic [11:0] mux_table;
   } cfg_type;

   // Result of one request before the distance is scaled.
   typedef struct packed {
      logic [3:0]  trigger_lines;
      logic [2:0]  mux_channel;
      logic        supply_on;
      logic        busy_res;
      logic        reading_valid;
      logic [1:0]  sensor_id;
      logic [15:0] pulse_ticks;
      logic        timed_out;
      logic        scan_done;
   } stage_type;

endpackage

@@ rtl/core/ultrasonic_ranger_scan_sequencer_top.sv @@
// Each request passes through the input register, the control result register and the
// distance stage's response register, which presents the response until it is taken.
// Throughput: one request per cycle while responses are taken without stalling.
// Pipeline stages still take requests while a response waits, until they are full.
// Reset is synchronous and active high; it empties all stages, idles the scan and
// restores the configuration defaults.
// ----------------------------------------------------------------------------
// Ultrasonic ranger scan sequencer
// Sequences trigger, echo capture and timeout over four rangers in turn.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_scan_sequencer_top
   import uss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // capture_time
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // trigger_lines, mux_channel, supply_on, busy_res,
                                    // sensor_id, pulse_ticks, distance_mm, timed_out, zeros
   output logic        rsp_tuser,   // reading_valid
   output logic        rsp_tlast,   // scan_done
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type     cfg;
   logic        in_valid_ff;
   cmd_type     in_cmd_ff;
   logic [15:0] in_cap_ff;
   logic        ctrl_ready;
   logic        ctrl_valid;
   stage_type   ctrl_res;
   logic        dist_ready;

   assign req_tready = !in_valid_ff || ctrl_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= cmd_type'(req_tuser);
         in_cap_ff <= req_tdata;
      end
   end

   uss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (ctrl_ready),
      .in_cmd    (in_cmd_ff),
      .in_cap    (in_cap_ff),
      .out_valid (ctrl_valid),
      .out_ready (dist_ready),
      .out_res   (ctrl_res)
   );

   uss_dist u_dist (
      .clock          (clock),
      .reset          (reset),
      .distance_scale (cfg.distance_scale),
      .in_valid       (ctrl_valid),
      .in_ready       (dist_ready),
      .in_res         (ctrl_res),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_tdata      (rsp_tdata),
      .out_tuser      (rsp_tuser),
      .out_tlast      (rsp_tlast)
   );

endmodule

@@ rtl/core/uss_csr.sv @@
// ----------------------------------------------------------------------------
// Ranger scan sequencer configuration registers
// Write-only register bank with reset defaults.
// ----------------------------------------------------------------------------
module uss_csr
   import uss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TRIGGER_TICKS: cfg_in.trigger_ticks     = csr_wdata[7:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks     = csr_wdata;
            CSR_CAPTURE_WRAP:  cfg_in.capture_wrap      = csr_wdata;
            CSR_POWER_TICKS:   cfg_in.power_cycle_ticks = csr_wdata[7:0];
            CSR_DIST_SCALE:    cfg_in.distance_scale    = csr_wdata;
            CSR_ORDER_TABLE:   cfg_in.order_table       = csr_wdata[7:0];
            CSR_MUX_TABLE:     cfg_in.mux_table         = csr_wdata[11:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks     <= 8'd10;
         cfg_ff.timeout_ticks     <= 16'd8000;
         cfg_ff.capture_wrap      <= 16'd19999;
         cfg_ff.power_cycle_ticks <= 8'd100;
         cfg_ff.distance_scale    <= 16'd11239;
         cfg_ff.order_table       <= 8'd216;
         cfg_ff.mux_table         <= 12'd1719;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/uss_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ranger scan sequencer control
// Scan state machine, pulse width and result register for each request.
// ----------------------------------------------------------------------------
`include "ultrasonic_ranger_scan_sequencer_top_macros.svh"

module uss_ctrl
   import uss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  cmd_type     in_cmd,
   input  logic [15:0] in_cap,
   output logic        out_valid,
   input  logic        out_ready,
   output stage_type   out_res
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  trig_cnt_ff, trig_cnt_in;
   logic [15:0] wait_cnt_ff, wait_cnt_in;
   logic [7:0]  power_cnt_ff, power_cnt_in;
   logic [15:0] echo_start_ff, echo_start_in;
   logic        restart_ff, restart_in;
   logic        res_valid_ff;
   stage_type   res_ff, res_in;

   logic        step;
   logic [7:0]  trig_inc, power_inc;
   logic [15:0] wait_inc;
   logic        measuring;
   logic        tick_timeout, fall_done, done, last;
   logic [17:0] wrap_sum;
   logic [15:0] echo_pulse, pulse;
   logic [1:0]  sensor_now, sensor_next;

   assign in_ready = !res_valid_ff || out_ready;
   assign step     = in_valid && in_ready;

   // Shared event decode for the next-state and result logic.
   always_comb begin
      trig_inc   = trig_cnt_ff + 8'd1;
      power_inc  = power_cnt_ff + 8'd1;
      wait_inc   = (wait_cnt_ff == 16'hFFFF) ? wait_cnt_ff : wait_cnt_ff + 16'd1;
      measuring  = (phase_ff == PHASE_TRIGGER) || (phase_ff == PHASE_RISE) ||
                   (phase_ff == PHASE_FALL);
      tick_timeout = (in_cmd == CMD_TICK) && measuring && (wait_inc >= cfg.timeout_ticks);
      fall_done    = (in_cmd == CMD_FALL) && (phase_ff == PHASE_FALL);
      done       = tick_timeout || fall_done;
      last       = (pos_ff >= POS_LAST);
      sensor_now = cfg.order_table[{pos_ff, 1'b0} +: 2];

      // When the capture counter has wrapped, the sum may fall below zero or
      // exceed sixteen bits, so it is clamped.
      wrap_sum = {2'b00, cfg.capture_wrap} - {2'b00, echo_start_ff} + {2'b00, in_cap};
      if (in_cap > echo_start_ff) begin
         echo_pulse = in_cap - echo_start_ff;
      end else if (wrap_sum[17]) begin
         echo_pulse = 16'd0;
      end else if (wrap_sum[16]) begin
         echo_pulse = 16'hFFFF;
      end else begin
         echo_pulse = wrap_sum[15:0];
      end

      if (tick_timeout) begin
         pulse = cfg.timeout_ticks;
      end else if (fall_done) begin
         pulse = echo_pulse;
      end else begin
         pulse = 16'd0;
      end
   end

   // Next state.
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      trig_cnt_in   = trig_cnt_ff;
      wait_cnt_in   = wait_cnt_ff;
      power_cnt_in  = power_cnt_ff;
      echo_start_in = echo_start_ff;
      restart_in    = restart_ff;

      unique case (in_cmd)
         CMD_START: begin
            if (phase_ff == PHASE_IDLE) begin
               pos_in = 2'd0;
               if (restart_ff) begin
                  restart_in   = 1'b0;
                  power_cnt_in = 8'd0;
                  phase_in     = PHASE_POWER;
               end else begin
                  phase_in    = PHASE_TRIGGER;
                  trig_cnt_in = 8'd0;
                  wait_cnt_in = 16'd0;
               end
            end
         end
         CMD_TICK: begin
            if (phase_ff == PHASE_POWER) begin
               power_cnt_in = power_inc;
               if (power_inc >= cfg.power_cycle_ticks) begin
                  phase_in    = PHASE_TRIGGER;
                  trig_cnt_in = 8'd0;
                  wait_cnt_in = 16'd0;
               end
            end else if (measuring) begin
               if (phase_ff == PHASE_TRIGGER) begin
                  trig_cnt_in = trig_inc;
                  if (trig_inc >= cfg.trigger_ticks) begin
                     phase_in = PHASE_RISE;
                  end
               end
               wait_cnt_in = wait_inc;
               if (tick_timeout) begin
                  restart_in = 1'b1;
               end
            end
         end
         CMD_RISE: begin
            if ((phase_ff == PHASE_RISE) || (phase_ff == PHASE_FALL)) begin
               echo_start_in = in_cap;
               phase_in      = PHASE_FALL;
            end
         end
         CMD_FALL: begin
            phase_in = phase_ff;
         end
         default: phase_in = phase_ff;
      endcase

      if (done) begin
         if (last) begin
            pos_in   = 2'd0;
            phase_in = PHASE_IDLE;
         end else begin
            pos_in      = pos_ff + 2'd1;
            phase_in    = PHASE_TRIGGER;
            trig_cnt_in = 8'd0;
            wait_cnt_in = 16'd0;
         end
      end
   end

   // Result fields, status taken after the request has been applied.
   always_comb begin
      sensor_next          = cfg.order_table[{pos_in, 1'b0} +: 2];
      res_in.trigger_lines = (phase_in == PHASE_TRIGGER) ? 4'(4'b0001 << sensor_next) : 4'd0;
      res_in.mux_channel   = 3'(cfg.mux_table >> (4'(sensor_next) * 4'd3));
      res_in.supply_on     = (phase_in != PHASE_POWER);
      res_in.busy_res      = (phase_in != PHASE_IDLE);
      res_in.reading_valid = done;
      res_in.sensor_id     = done ? sensor_now : 2'd0;
      res_in.pulse_ticks   = pulse;
      res_in.timed_out     = tick_timeout;
      res_in.scan_done     = done && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         pos_ff        <= 2'd0;
         trig_cnt_ff   <= 8'd0;
         wait_cnt_ff   <= 16'd0;
         power_cnt_ff  <= 8'd0;
         echo_start_ff <= 16'd0;
         restart_ff    <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         if (step) begin
            phase_ff      <= phase_in;
            pos_ff        <= pos_in;
            trig_cnt_ff   <= trig_cnt_in;
            wait_cnt_ff   <= wait_cnt_in;
            power_cnt_ff  <= power_cnt_in;
            echo_start_ff <= echo_start_in;
            restart_ff    <= restart_in;
         end
         if (in_ready) begin
            res_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_res   = res_ff;

   `USS_ASSERT_NEXT(a_last_goes_idle, clock, reset, step && done && last, phase_ff == PHASE_IDLE)
   `USS_ASSERT_NEXT(a_timeout_arms_restart, clock, reset, step && tick_timeout, restart_ff)
   `USS_ASSERT_SAME(a_position_in_scan, clock, reset, 1'b1, pos_ff <= POS_LAST)
   `USS_ASSERT_SAME(a_power_without_restart, clock, reset, phase_ff == PHASE_POWER, !restart_ff)

endmodule

@@ rtl/core/uss_dist.sv @@
// ----------------------------------------------------------------------------
// Ranger scan sequencer distance stage
// Scales the pulse width to millimetres and holds the outgoing response.
// ----------------------------------------------------------------------------
module uss_dist
   import uss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] distance_scale,
   input  logic        in_valid,
   output logic        in_ready,
   input  stage_type   in_res,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [47:0] out_tdata,  // trigger_lines, mux_channel, supply_on, busy_res,
                                   // sensor_id, pulse_ticks, distance_mm, timed_out, zeros
   output logic        out_tuser,  // reading_valid
   output logic        out_tlast   // scan_done
);

   logic        valid_ff;
   stage_type   res_ff;
   logic [13:0] dist_ff, dist_in;
   logic [31:0] product;
   logic [32:0] rounded;

   assign in_ready = !valid_ff || out_ready;

   // Q16 scale with round half up, saturated to fourteen bits.
   always_comb begin
      product = in_res.pulse_ticks * distance_scale;
      rounded = {1'b0, product} + 33'd32768;
      dist_in = (rounded[32:30] != 3'd0) ? 14'h3FFF : rounded[29:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ff  <= in_res;
         dist_ff <= dist_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tdata = {6'd0, res_ff.timed_out, dist_ff, res_ff.pulse_ticks, res_ff.sensor_id,
                       res_ff.busy_res, res_ff.supply_on, res_ff.mux_channel,
                       res_ff.trigger_lines};
   assign out_tuser = res_ff.reading_valid;
   assign out_tlast = res_ff.scan_done;

endmodule

@@ tb/sv/ultrasonic_ranger_scan_sequencer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Ranger scan sequencer testbench
// Drives scan commands, echo edges and ticks into the sequencer and checks
// every response against a cycle-free model of the scan, over several
// register settings and with random idling on both streams.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_scan_sequencer_top_tb;
   import uss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES = 11;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] capture;
   } request_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  position;
      logic [7:0]  trigger_count;
      logic [15:0] wait_count;
      logic [7:0]  power_count;
      logic [15:0] echo_start;
      logic        restart_pending;
   } scan_state_type;

   typedef struct packed {
      logic [3:0]  trigger_lines;
      logic [2:0]  mux_channel;
      logic        supply_on;
      logic        busy;
      logic        reading_valid;
      logic [1:0]  sensor_id;
      logic [15:0] pulse_ticks;
      logic [13:0] distance_mm;
      logic        timed_out;
      logic        scan_done;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   cfg_type        csr_shadow;
   scan_state_type model_state;
   scan_state_type plan_state;
   request_type    pending_requests[$];
   reading_type    expected_readings[$];
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             mismatches = 0;
   int             cycles = 0;

   ultrasonic_ranger_scan_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advances one copy of the scan state by a request and gives its response.
   task automatic advance_scan(inout scan_state_type s, input request_type rq,
                               output reading_type r);
      logic        done;
      logic        tout;
      logic [15:0] pulse;
      logic [1:0]  sid;
      logic [1:0]  sensor;
      logic [32:0] scaled;
      int          width;
      done  = 1'b0;
      tout  = 1'b0;
      pulse = '0;
      sid   = '0;
      r     = '0;
      case (rq.cmd)
         CMD_START: begin
            if (s.phase == PHASE_IDLE) begin
               s.position = '0;
               if (s.restart_pending) begin
                  s.restart_pending = 1'b0;
                  s.power_count = '0;
                  s.phase = PHASE_POWER;
               end else begin
                  s.phase = PHASE_TRIGGER;
                  s.trigger_count = '0;
                  s.wait_count = '0;
               end
            end
         end
         CMD_TICK: begin
            if (s.phase == PHASE_POWER) begin
               s.power_count = s.power_count + 8'd1;
               if (s.power_count >= csr_shadow.power_cycle_ticks) begin
                  s.phase = PHASE_TRIGGER;
                  s.trigger_count = '0;
                  s.wait_count = '0;
               end
            end else if (s.phase != PHASE_IDLE) begin
               if (s.phase == PHASE_TRIGGER) begin
                  s.trigger_count = s.trigger_count + 8'd1;
                  if (s.trigger_count >= csr_shadow.trigger_ticks)
                     s.phase = PHASE_RISE;
               end
               if (s.wait_count != 16'hFFFF)
                  s.wait_count = s.wait_count + 16'd1;
               // The timeout is counted from the start of the trigger pulse.
               if (s.wait_count >= csr_shadow.timeout_ticks) begin
                  done = 1'b1;
                  tout = 1'b1;
                  pulse = csr_shadow.timeout_ticks;
                  s.restart_pending = 1'b1;
               end
            end
         end
         CMD_RISE: begin
            if (s.phase == PHASE_RISE || s.phase == PHASE_FALL) begin
               s.echo_start = rq.capture;
               s.phase = PHASE_FALL;
            end
         end
         default: begin
            if (s.phase == PHASE_FALL) begin
               if (rq.capture > s.echo_start)
                  width = int'(rq.capture) - int'(s.echo_start);
               else
                  width = int'(csr_shadow.capture_wrap) - int'(s.echo_start) + int'(rq.capture);
               if (width < 0)
                  width = 0;
               if (width > 65535)
                  width = 65535;
               pulse = 16'(width);
               done = 1'b1;
            end
         end
      endcase
      if (done) begin
         sid = csr_shadow.order_table[s.position*2 +: 2];
         r.scan_done = (s.position >= POS_LAST);
         if (r.scan_done) begin
            s.position = '0;
            s.phase = PHASE_IDLE;
         end else begin
            s.position = s.position + 2'd1;
            s.phase = PHASE_TRIGGER;
            s.trigger_count = '0;
            s.wait_count = '0;
         end
      end
      sensor = csr_shadow.order_table[s.position*2 +: 2];
      r.trigger_lines = (s.phase == PHASE_TRIGGER) ? (4'b0001 << sensor) : 4'b0000;
      r.mux_channel = csr_shadow.mux_table[sensor*3 +: 3];
      r.supply_on = (s.phase != PHASE_POWER);
      r.busy = (s.phase != PHASE_IDLE);
      if (done) begin
         scaled = 33'(pulse) * 33'(csr_shadow.distance_scale) + 33'd32768;
         r.reading_valid = 1'b1;
         r.sensor_id = sid;
         r.pulse_ticks = pulse;
         r.distance_mm = (scaled[32:16] > 17'd16383) ? 14'h3FFF : scaled[29:16];
         r.timed_out = tout;
      end
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      mismatches++;
   endtask

   task automatic check_reading(input logic [47:0] data, input logic valid, input logic last);
      reading_type want;
      if (expected_readings.size() == 0) begin
         report_mismatch("response with no request outstanding", data, 0);
      end else begin
         want = expected_readings.pop_front();
         if (data[3:0] !== want.trigger_lines)
            report_mismatch("trigger_lines", data[3:0], want.trigger_lines);
         if (data[6:4] !== want.mux_channel)
            report_mismatch("mux_channel", data[6:4], want.mux_channel);
         if (data[7] !== want.supply_on)
            report_mismatch("supply_on", data[7], want.supply_on);
         if (data[8] !== want.busy)
            report_mismatch("busy_res", data[8], want.busy);
         if (valid !== want.reading_valid)
            report_mismatch("reading_valid", valid, want.reading_valid);
         if (data[10:9] !== want.sensor_id)
            report_mismatch("sensor_id", data[10:9], want.sensor_id);
         if (data[26:11] !== want.pulse_ticks)
            report_mismatch("pulse_ticks", data[26:11], want.pulse_ticks);
         if (data[40:27] !== want.distance_mm)
            report_mismatch("distance_mm", data[40:27], want.distance_mm);
         if (data[41] !== want.timed_out)
            report_mismatch("timed_out", data[41], want.timed_out);
         if (last !== want.scan_done)
            report_mismatch("scan_done", last, want.scan_done);
         if (data[47:42] !== 6'd0)
            report_mismatch("tdata padding", data[47:42], 0);
      end
   endtask

   // Request driver; the model is advanced at the edge where a request is taken.
   always @(posedge clock) begin
      reading_type want;
      request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.cmd = cmd_type'(req_tuser);
            rq.capture = req_tdata;
            advance_scan(model_state, rq, want);
            expected_readings.push_back(want);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= rq.cmd;
               req_tdata <= rq.capture;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_reading(rsp_tdata, rsp_tuser, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_request(input cmd_type cmd, input logic [15:0] capture);
      request_type rq;
      reading_type unused;
      rq.cmd = cmd;
      rq.capture = capture;
      advance_scan(plan_state, rq, unused);
      pending_requests.push_back(rq);
   endtask

   function automatic logic [15:0] pick_capture();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return plan_state.echo_start;
         3, 4: return plan_state.echo_start + 16'($urandom_range(1, 200));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly well-formed scans with random timing and captures, some noise.
   task automatic queue_scan_traffic(input int count);
      int      roll;
      cmd_type cmd;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         cmd = cmd_type'($urandom_range(0, 3));
         case (plan_state.phase)
            PHASE_IDLE:    if (roll < 80) cmd = CMD_START;
            PHASE_POWER:   if (roll < 90) cmd = CMD_TICK;
            PHASE_TRIGGER: if (roll < 85) cmd = CMD_TICK;
            PHASE_RISE:    if (roll < 25) cmd = CMD_RISE; else if (roll < 90) cmd = CMD_TICK;
            default: begin
               if (roll < 25)
                  cmd = CMD_FALL;
               else if (roll < 35)
                  cmd = CMD_RISE;
               else if (roll < 90)
                  cmd = CMD_TICK;
            end
         endcase
         queue_request(cmd, pick_capture());
      end
   endtask

   // Brings the planned scan back to idle so that the registers may be written.
   task automatic queue_scan_end();
      while (plan_state.phase != PHASE_IDLE) begin
         case (plan_state.phase)
            PHASE_RISE: queue_request(CMD_RISE, pick_capture());
            PHASE_FALL: queue_request(CMD_FALL, pick_capture());
            default:    queue_request(CMD_TICK, pick_capture());
         endcase
      end
   endtask

   task automatic queue_directed();
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_RISE, 16'h0005);
      queue_request(CMD_FALL, 16'h0009);
      queue_request(CMD_START, 16'hFFFF);
      queue_request(CMD_START, 16'h0000);
      queue_request(CMD_RISE, 16'h0001);
      queue_request(CMD_FALL, 16'h0002);
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_FALL, 16'h0003);
      queue_request(CMD_RISE, 16'hFFFF);
      queue_request(CMD_RISE, 16'h000A);
      // An end stamp equal to the start one goes through the wrap formula.
      queue_request(CMD_FALL, 16'h000A);
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_RISE, 16'h0000);
      queue_request(CMD_FALL, 16'hFFFF);
      repeat (6) queue_request(CMD_TICK, 16'h1234);
      queue_request(CMD_START, 16'h0000);
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_TICK, 16'h0000);
      queue_request(CMD_RISE, 16'd100);
      queue_request(CMD_FALL, 16'd200);
      queue_request(CMD_START, 16'h0000);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
   endtask

   task automatic load_registers(input cfg_type c);
      write_csr(CSR_TRIGGER_TICKS, 16'(c.trigger_ticks));
      write_csr(CSR_TIMEOUT_TICKS, c.timeout_ticks);
      write_csr(CSR_CAPTURE_WRAP, c.capture_wrap);
      write_csr(CSR_POWER_TICKS, 16'(c.power_cycle_ticks));
      write_csr(CSR_DIST_SCALE, c.distance_scale);
      write_csr(CSR_ORDER_TABLE, 16'(c.order_table));
      write_csr(CSR_MUX_TABLE, 16'(c.mux_table));
      @(posedge clock);
      csr_we <= 1'b0;
      csr_shadow = c;
   endtask

   initial begin
      cfg_type c;
      csr_shadow = '{trigger_ticks: 8'd10, timeout_ticks: 16'd8000, capture_wrap: 16'd19999,
                     power_cycle_ticks: 8'd100, distance_scale: 16'd11239,
                     order_table: 8'd216, mux_table: 12'd1719};
      model_state = '0;
      plan_state = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         c.trigger_ticks = 8'($urandom_range(0, 12));
         c.timeout_ticks = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(1, 60));
         c.capture_wrap = 16'($urandom_range(0, 65535));
         c.power_cycle_ticks = 8'($urandom_range(0, 12));
         c.distance_scale = 16'($urandom_range(0, 65535));
         c.order_table = 8'($urandom_range(0, 255));
         c.mux_table = 12'($urandom_range(0, 4095));
         case (ph)
            1: c = '{8'd2, 16'd6, 16'hFFFF, 8'd2, 16'hFFFF, 8'h1B, 12'hFAC};
            // Timeout at the first tick, inside the longest trigger pulse.
            2: c = '{8'd255, 16'd1, 16'hFFFF, 8'd255, 16'hFFFF, 8'hFF, 12'hFFF};
            3: c = '0;
            4: c = '{8'd1, 16'hFFFF, 16'd1, 8'd1, 16'hFFFF, c.order_table, c.mux_table};
            default: ;
         endcase
         if (ph != 0)
            load_registers(c);
         case (ph)
            0: queue_scan_traffic(40);
            1: queue_directed();
            2: queue_scan_traffic(60);
            3: queue_scan_traffic(80);
            4: queue_scan_traffic(150);
            default: queue_scan_traffic(130);
         endcase
         queue_scan_end();
         // The sender holds off here until every response has come back.
         while (pending_requests.size() != 0 || req_tvalid || expected_readings.size() != 0)
            @(negedge clock);
         repeat (4) @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/uss_pkg.sv
rtl/core/uss_csr.sv
rtl/core/uss_ctrl.sv
rtl/core/uss_dist.sv
rtl/core/ultrasonic_ranger_scan_sequencer_top.sv
tb/sv/ultrasonic_ranger_scan_sequencer_top_tb.sv
